// ----- src/fqrr_pkg.sv -----
package fqrr_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int OCC_W = 5;

   localparam logic [1:0] ACT_PUSH    = 2'd0;
   localparam logic [1:0] ACT_POP     = 2'd1;
   localparam logic [1:0] ACT_REMOVE  = 2'd2;
   localparam logic [1:0] ACT_REVERSE = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [VAL_W-1:0] VAL_MINUS_ONE = '1;

   typedef struct packed {
      logic [1:0]              action;
      logic signed [VAL_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_value;
      logic [1:0]              status;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [VAL_W-1:0] data;
   } store_wr_type;

   // Physical slot of a logical position counted from the head.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front} + {1'b0, pos};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ----- src/fqrr_store.sv -----
module fqrr_store (
   input  logic                         clock,
   input  fqrr_pkg::store_wr_type       wr,
   input  logic [fqrr_pkg::IDX_W-1:0]   rd_addr,
   output logic [fqrr_pkg::VAL_W-1:0]   rd_data
);
   import fqrr_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fifo_queue_remove_reverse_unit.sv -----
// Bounded FIFO queue of signed 32-bit values with push, pop, remove-value and
// reverse. A request beat is taken when start is high and busy is low; each
// request gives exactly one response beat, shown on rsp_data for one cycle
// with rsp_valid high. The receiver cannot hold responses off, and none is
// needed: a response register holds each result for its one cycle.
// Push, pop of an empty queue, remove on an empty queue and reverse of fewer
// than two entries answer in the cycle after the request; busy stays low.
// Pop passes through S_POP, where it takes the head from the registered read
// data, and holds busy for one cycle. Remove reads the store one entry at a
// time: S_FIND_RD and S_FIND_CMP for each entry compared, S_SH_RD and S_SH_WR
// for each later entry moved toward the head. Reverse takes S_RV_A, S_RV_B,
// S_RV_WA and S_RV_WB for each swapped pair. These steps follow from the
// store's single read port with registered read data and its single write
// port, shared by every step. The next request is taken in the cycle its
// predecessor's response shows. Reset empties the queue at once; store
// contents are not cleared, since no entry is read before it is written.
module fifo_queue_remove_reverse_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fqrr_pkg::req_type req_data,
   output logic              rsp_valid,
   output fqrr_pkg::rsp_type rsp_data
);
   import fqrr_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_POP      = 4'd1;
   localparam logic [3:0] S_FIND_RD  = 4'd2;
   localparam logic [3:0] S_FIND_CMP = 4'd3;
   localparam logic [3:0] S_SH_RD    = 4'd4;
   localparam logic [3:0] S_SH_WR    = 4'd5;
   localparam logic [3:0] S_RV_A     = 4'd6;
   localparam logic [3:0] S_RV_B     = 4'd7;
   localparam logic [3:0] S_RV_WA    = 4'd8;
   localparam logic [3:0] S_RV_WB    = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [VAL_W-1:0] tmp_ff, tmp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   store_wr_type     wr;
   logic [IDX_W-1:0] rd_addr;
   logic [VAL_W-1:0] rd_data;
   logic             accept;

   fqrr_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      idx_in       = idx_ff;
      hi_in        = hi_ff;
      value_in     = value_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr           = '0;
      rd_addr      = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = req_data.data_value;
               idx_in   = '0;
               unique case (req_data.action)
                  ACT_PUSH: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.out_value = '0;
                     if (count_ff >= CNT_W'(DEPTH)) begin
                        rsp_in.status    = ST_FULL;
                        rsp_in.occupancy = OCC_W'(count_ff);
                     end else begin
                        wr.en   = 1'b1;
                        wr.addr = slot_of(front_ff, count_ff);
                        wr.data = req_data.data_value;
                        count_in         = count_ff + 1'b1;
                        rsp_in.status    = ST_OK;
                        rsp_in.occupancy = OCC_W'(count_ff + 1'b1);
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.out_value = VAL_MINUS_ONE;
                        rsp_in.status    = ST_EMPTY;
                        rsp_in.occupancy = '0;
                     end else begin
                        // The head is being read at this edge.
                        state_in = S_POP;
                     end
                  end
                  ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.out_value = '0;
                        rsp_in.status    = ST_NOT_FOUND;
                        rsp_in.occupancy = '0;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
                  ACT_REVERSE: begin
                     if (count_ff > CNT_W'(1)) begin
                        hi_in    = count_ff - 1'b1;
                        state_in = S_RV_A;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.out_value = '0;
                        rsp_in.status    = ST_OK;
                        rsp_in.occupancy = OCC_W'(count_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            front_in         = slot_of(front_ff, CNT_W'(1));
            count_in         = count_ff - 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_in.out_value = rd_data;
            rsp_in.status    = ST_OK;
            rsp_in.occupancy = OCC_W'(count_ff - 1'b1);
            state_in         = S_IDLE;
         end
         S_FIND_RD: begin
            rd_addr  = slot_of(front_ff, idx_ff);
            state_in = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (rd_data == value_ff) begin
               if (idx_ff + 1'b1 < count_ff) begin
                  state_in = S_SH_RD;
               end else begin
                  count_in         = count_ff - 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_in.out_value = '0;
                  rsp_in.status    = ST_OK;
                  rsp_in.occupancy = OCC_W'(count_ff - 1'b1);
                  state_in         = S_IDLE;
               end
            end else if (idx_ff + 1'b1 == count_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_value = '0;
               rsp_in.status    = ST_NOT_FOUND;
               rsp_in.occupancy = OCC_W'(count_ff);
               state_in         = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_FIND_RD;
            end
         end
         S_SH_RD: begin
            rd_addr  = slot_of(front_ff, idx_ff + 1'b1);
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            wr.en   = 1'b1;
            wr.addr = slot_of(front_ff, idx_ff);
            wr.data = rd_data;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff + CNT_W'(2) < count_ff) begin
               state_in = S_SH_RD;
            end else begin
               count_in         = count_ff - 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_in.out_value = '0;
               rsp_in.status    = ST_OK;
               rsp_in.occupancy = OCC_W'(count_ff - 1'b1);
               state_in         = S_IDLE;
            end
         end
         S_RV_A: begin
            rd_addr  = slot_of(front_ff, idx_ff);
            state_in = S_RV_B;
         end
         S_RV_B: begin
            rd_addr  = slot_of(front_ff, hi_ff);
            tmp_in   = rd_data;
            state_in = S_RV_WA;
         end
         S_RV_WA: begin
            wr.en    = 1'b1;
            wr.addr  = slot_of(front_ff, idx_ff);
            wr.data  = rd_data;
            state_in = S_RV_WB;
         end
         S_RV_WB: begin
            wr.en   = 1'b1;
            wr.addr = slot_of(front_ff, hi_ff);
            wr.data = tmp_ff;
            idx_in  = idx_ff + 1'b1;
            hi_in   = hi_ff - 1'b1;
            // Another pair remains while the inner ends have not met.
            if (idx_ff + CNT_W'(2) < hi_ff) begin
               state_in = S_RV_A;
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_value = '0;
               rsp_in.status    = ST_OK;
               rsp_in.occupancy = OCC_W'(count_ff);
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      hi_ff    <= hi_in;
      value_ff <= value_in;
      tmp_ff   <= tmp_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
